@@ src/srv_pkg.sv @@
// Shared types, constants and width helpers for the refraction pipeline.
`timescale 1ns / 1ps

package srv_pkg;

    localparam int WORD_W   = 16;
    localparam int ETA_W    = 15;
    localparam int WORD_MAX = 32767;
    localparam int WORD_MIN = -32768;

    // element 0 is x, 1 is y, 2 is z
    typedef logic [2:0][WORD_W-1:0] vec_t;
    typedef logic [ETA_W-1:0]       eta_t;

    // width of the negated dot product, wide enough to hold 2^(2F) as well
    function automatic int dot_w(int frac);
        return (2 * frac + 2 > 35) ? 2 * frac + 2 : 35;
    endfunction

    // width of the rounded cosine
    function automatic int cos_w(int frac);
        return dot_w(frac) - frac;
    endfunction

    // width of the square root result; the radicand has twice as many bits
    function automatic int root_w(int frac);
        return (frac + 1 > 16) ? frac + 1 : 16;
    endfunction

endpackage

@@ src/srv_if.sv @@
// Stream interfaces for incident ray words and refracted direction words.
`timescale 1ns / 1ps

interface srv_ray_if
    import srv_pkg::*;
();
    logic              valid;
    logic              ready;
    logic signed [WORD_W-1:0] in_dir_x;
    logic signed [WORD_W-1:0] in_dir_y;
    logic signed [WORD_W-1:0] in_dir_z;
    logic signed [WORD_W-1:0] normal_x;
    logic signed [WORD_W-1:0] normal_y;
    logic signed [WORD_W-1:0] normal_z;
    logic [ETA_W-1:0]         index_ratio;

    modport source (
        output valid, in_dir_x, in_dir_y, in_dir_z,
        output normal_x, normal_y, normal_z, index_ratio,
        input  ready
    );
    modport sink (
        input  valid, in_dir_x, in_dir_y, in_dir_z,
        input  normal_x, normal_y, normal_z, index_ratio,
        output ready
    );
endinterface

interface srv_dir_if
    import srv_pkg::*;
();
    logic              valid;
    logic              ready;
    logic signed [WORD_W-1:0] out_dir_x;
    logic signed [WORD_W-1:0] out_dir_y;
    logic signed [WORD_W-1:0] out_dir_z;

    modport source (
        output valid, out_dir_x, out_dir_y, out_dir_z,
        input  ready
    );
    modport sink (
        input  valid, out_dir_x, out_dir_y, out_dir_z,
        output ready
    );
endinterface

@@ src/srv_dot.sv @@
// Dot product of direction and normal, negated, clamped at one and rounded.
`timescale 1ns / 1ps

module srv_dot
    import srv_pkg::*;
#(
    parameter int FRAC_BITS = 12
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic up_valid,
    output logic up_ready,
    input  vec_t up_dir,
    input  vec_t up_nrm,
    input  eta_t up_eta,
    output logic dn_valid,
    input  logic dn_ready,
    output vec_t dn_dir,
    output vec_t dn_nrm,
    output eta_t dn_eta,
    output logic signed [cos_w(FRAC_BITS)-1:0] dn_cos
);

    localparam int DW = dot_w(FRAC_BITS);
    localparam int CW = cos_w(FRAC_BITS);
    localparam int PW = 2 * WORD_W;
    localparam logic signed [DW-1:0] ONE2 = DW'(1) <<< (2 * FRAC_BITS);
    localparam logic signed [DW-1:0] HALF = DW'(1) <<< (FRAC_BITS - 1);

    logic [2:0] v_reg, v_next, v_in;
    logic [3:0] go;

    logic signed [PW-1:0] prod_next [3];
    logic signed [PW-1:0] prod_reg  [3];
    logic signed [DW-1:0] nd_next, nd_reg;
    logic signed [DW-1:0] clamp_val, rsum, cos_full;
    logic signed [CW-1:0] cos_next, cos_reg;
    vec_t dir_reg [3];
    vec_t nrm_reg [3];
    eta_t eta_reg [3];

    // per-stage bubble collapse: a stage loads when empty or when it drains
    always_comb
    begin
        v_in  = {v_reg[1:0], up_valid};
        go[3] = dn_ready;
        for (int k = 2; k >= 0; k--)
        begin
            go[k] = !v_reg[k] || go[k+1];
        end
        for (int k = 0; k < 3; k++)
        begin
            v_next[k] = go[k] ? v_in[k] : v_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            prod_next[i] = $signed(up_dir[i]) * $signed(up_nrm[i]);
        end
    end

    always_comb
    begin
        nd_next = '0;
        for (int i = 0; i < 3; i++)
        begin
            nd_next = nd_next - DW'(prod_reg[i]);
        end
    end

    always_comb
    begin
        clamp_val = (nd_reg > ONE2) ? ONE2 : nd_reg;
        rsum      = clamp_val + HALF;
        cos_full  = rsum >>> FRAC_BITS;
        cos_next  = cos_full[CW-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (go[0] && v_in[0])
        begin
            prod_reg   <= prod_next;
            dir_reg[0] <= up_dir;
            nrm_reg[0] <= up_nrm;
            eta_reg[0] <= up_eta;
        end
        if (go[1] && v_in[1])
        begin
            nd_reg     <= nd_next;
            dir_reg[1] <= dir_reg[0];
            nrm_reg[1] <= nrm_reg[0];
            eta_reg[1] <= eta_reg[0];
        end
        if (go[2] && v_in[2])
        begin
            cos_reg    <= cos_next;
            dir_reg[2] <= dir_reg[1];
            nrm_reg[2] <= nrm_reg[1];
            eta_reg[2] <= eta_reg[1];
        end
    end

    assign up_ready = go[0];
    assign dn_valid = v_reg[2];
    assign dn_dir   = dir_reg[2];
    assign dn_nrm   = nrm_reg[2];
    assign dn_eta   = eta_reg[2];
    assign dn_cos   = cos_reg;

endmodule

@@ src/srv_perp.sv @@
// Perpendicular part eta*(r + cos*n), its squared length and |1 - |p|^2|.
`timescale 1ns / 1ps

module srv_perp
    import srv_pkg::*;
#(
    parameter int FRAC_BITS = 12
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic up_valid,
    output logic up_ready,
    input  vec_t up_dir,
    input  vec_t up_nrm,
    input  eta_t up_eta,
    input  logic signed [cos_w(FRAC_BITS)-1:0] up_cos,
    output logic dn_valid,
    input  logic dn_ready,
    output vec_t dn_par,
    output vec_t dn_nrm,
    output logic [2*root_w(FRAC_BITS)-1:0] dn_q
);

    localparam int CW  = cos_w(FRAC_BITS);
    localparam int CNW = CW + WORD_W;
    localparam int TA  = CW + 18;
    localparam int TB  = 2 * FRAC_BITS + 18;
    localparam int TW  = (TA > TB) ? TA : TB;
    localparam int SW  = FRAC_BITS + 17;
    localparam int EW  = SW + WORD_W;
    localparam int YW  = EW + 1;
    localparam int SQW = 2 * WORD_W - 1;
    localparam int QW  = 2 * root_w(FRAC_BITS);
    localparam int DFW = QW + 1;
    localparam int NS  = 6;

    localparam logic signed [TW-1:0]  HALF_T = TW'(1) <<< (FRAC_BITS - 1);
    localparam logic signed [YW-1:0]  HALF_Y = YW'(1) <<< (FRAC_BITS - 1);
    // |s| beyond 2^(F+16) saturates p for any nonzero eta, so s is bounded there
    localparam logic signed [TW-1:0]  S_HI   = (TW'(1) <<< (FRAC_BITS + 16)) - TW'(1);
    localparam logic signed [TW-1:0]  S_LO   = -(TW'(1) <<< (FRAC_BITS + 16));
    localparam logic signed [YW-1:0]  SAT_HI = YW'(WORD_MAX);
    localparam logic signed [YW-1:0]  SAT_LO = YW'(WORD_MIN);
    localparam logic signed [DFW-1:0] ONE2   = DFW'(1) <<< (2 * FRAC_BITS);

    logic [NS-1:0] v_reg, v_next, v_in;
    logic [NS:0]   go;

    logic signed [CNW-1:0] cn_next [3];
    logic signed [CNW-1:0] cn_reg  [3];
    logic signed [SW-1:0]  s_next  [3];
    logic signed [SW-1:0]  s_reg   [3];
    logic signed [EW-1:0]  e_next  [3];
    logic signed [EW-1:0]  e_reg   [3];
    vec_t                  par_next;
    logic [SQW-1:0]        sq_next [3];
    logic [SQW-1:0]        sq_reg  [3];
    logic [QW-1:0]         q_next, q_reg;
    vec_t dir_reg;
    vec_t nrm_reg [NS];
    eta_t eta_reg [2];
    vec_t par_reg [3:5];

    always_comb
    begin
        v_in   = {v_reg[NS-2:0], up_valid};
        go[NS] = dn_ready;
        for (int k = NS - 1; k >= 0; k--)
        begin
            go[k] = !v_reg[k] || go[k+1];
        end
        for (int k = 0; k < NS; k++)
        begin
            v_next[k] = go[k] ? v_in[k] : v_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            cn_next[i] = up_cos * $signed(up_nrm[i]);
        end
    end

    always_comb
    begin : s_calc
        logic signed [TW-1:0] t;
        logic signed [TW-1:0] sr;
        for (int i = 0; i < 3; i++)
        begin
            t  = (TW'($signed(dir_reg[i])) <<< FRAC_BITS) + TW'(cn_reg[i]) + HALF_T;
            sr = t >>> FRAC_BITS;
            if (sr > S_HI)
            begin
                sr = S_HI;
            end
            else if (sr < S_LO)
            begin
                sr = S_LO;
            end
            s_next[i] = sr[SW-1:0];
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            e_next[i] = $signed({1'b0, eta_reg[1]}) * s_reg[i];
        end
    end

    always_comb
    begin : p_calc
        logic signed [YW-1:0] y;
        for (int i = 0; i < 3; i++)
        begin
            y = (YW'(e_reg[i]) + HALF_Y) >>> FRAC_BITS;
            if (y > SAT_HI)
            begin
                y = SAT_HI;
            end
            else if (y < SAT_LO)
            begin
                y = SAT_LO;
            end
            par_next[i] = y[WORD_W-1:0];
        end
    end

    always_comb
    begin : sq_calc
        logic signed [2*WORD_W-1:0] sq;
        for (int i = 0; i < 3; i++)
        begin
            sq         = $signed(par_reg[3][i]) * $signed(par_reg[3][i]);
            sq_next[i] = sq[SQW-1:0];
        end
    end

    always_comb
    begin : q_calc
        logic signed [DFW-1:0] diff;
        diff = ONE2;
        for (int i = 0; i < 3; i++)
        begin
            diff = diff - DFW'(sq_reg[i]);
        end
        if (diff < 0)
        begin
            diff = -diff;
        end
        q_next = diff[QW-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (go[0] && v_in[0])
        begin
            cn_reg     <= cn_next;
            dir_reg    <= up_dir;
            nrm_reg[0] <= up_nrm;
            eta_reg[0] <= up_eta;
        end
        if (go[1] && v_in[1])
        begin
            s_reg      <= s_next;
            nrm_reg[1] <= nrm_reg[0];
            eta_reg[1] <= eta_reg[0];
        end
        if (go[2] && v_in[2])
        begin
            e_reg      <= e_next;
            nrm_reg[2] <= nrm_reg[1];
        end
        if (go[3] && v_in[3])
        begin
            par_reg[3] <= par_next;
            nrm_reg[3] <= nrm_reg[2];
        end
        if (go[4] && v_in[4])
        begin
            sq_reg     <= sq_next;
            par_reg[4] <= par_reg[3];
            nrm_reg[4] <= nrm_reg[3];
        end
        if (go[5] && v_in[5])
        begin
            q_reg      <= q_next;
            par_reg[5] <= par_reg[4];
            nrm_reg[5] <= nrm_reg[4];
        end
    end

    assign up_ready = go[0];
    assign dn_valid = v_reg[NS-1];
    assign dn_par   = par_reg[5];
    assign dn_nrm   = nrm_reg[NS-1];
    assign dn_q     = q_reg;

endmodule

@@ src/srv_sqrt.sv @@
// Pipelined integer square root, one result bit per stage.
`timescale 1ns / 1ps

module srv_sqrt
    import srv_pkg::*;
#(
    parameter int FRAC_BITS = 12
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic up_valid,
    output logic up_ready,
    input  logic [2*root_w(FRAC_BITS)-1:0] up_q,
    input  vec_t up_par,
    input  vec_t up_nrm,
    output logic dn_valid,
    input  logic dn_ready,
    output logic [root_w(FRAC_BITS)-1:0] dn_root,
    output vec_t dn_par,
    output vec_t dn_nrm
);

    localparam int RW = root_w(FRAC_BITS);
    localparam int QW = 2 * RW;
    localparam int MW = RW + 2;
    localparam int CUW = RW + 4;

    logic [RW-1:0] v_reg, v_next, v_in;
    logic [RW:0]   go;

    // remainder and remaining radicand bits are not needed after the last step
    logic [MW-1:0] rem_reg  [RW-1];
    logic [QW-1:0] bits_reg [RW-1];
    logic [RW-1:0] root_reg [RW];
    vec_t          par_reg  [RW];
    vec_t          nrm_reg  [RW];

    always_comb
    begin
        v_in   = {v_reg[RW-2:0], up_valid};
        go[RW] = dn_ready;
        for (int k = RW - 1; k >= 0; k--)
        begin
            go[k] = !v_reg[k] || go[k+1];
        end
        for (int k = 0; k < RW; k++)
        begin
            v_next[k] = go[k] ? v_in[k] : v_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    for (genvar k = 0; k < RW; k++)
    begin : g_step
        logic [MW-1:0]  rem_in;
        logic [QW-1:0]  bits_in;
        logic [RW-1:0]  root_in;
        vec_t           par_in;
        vec_t           nrm_in;
        logic [CUW-1:0] cur;
        logic [CUW-1:0] trial;
        logic [CUW-1:0] diff;
        logic           take;
        logic [MW-1:0]  rem_next;
        logic [RW-1:0]  root_next;

        if (k == 0)
        begin : g_first
            assign rem_in  = '0;
            assign bits_in = up_q;
            assign root_in = '0;
            assign par_in  = up_par;
            assign nrm_in  = up_nrm;
        end
        else
        begin : g_rest
            assign rem_in  = rem_reg[k-1];
            assign bits_in = bits_reg[k-1];
            assign root_in = root_reg[k-1];
            assign par_in  = par_reg[k-1];
            assign nrm_in  = nrm_reg[k-1];
        end

        // bring down the next bit pair and try root*4 + 1
        always_comb
        begin
            cur       = {rem_in, bits_in[QW-1 -: 2]};
            trial     = {2'b00, root_in, 2'b01};
            diff      = cur - trial;
            take      = (cur >= trial);
            rem_next  = take ? diff[MW-1:0] : cur[MW-1:0];
            root_next = {root_in[RW-2:0], take};
        end

        always_ff @(posedge clk)
        begin
            if (go[k] && v_in[k])
            begin
                root_reg[k] <= root_next;
                par_reg[k]  <= par_in;
                nrm_reg[k]  <= nrm_in;
            end
        end

        if (k < RW - 1)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                if (go[k] && v_in[k])
                begin
                    rem_reg[k]  <= rem_next;
                    bits_reg[k] <= {bits_in[QW-3:0], 2'b00};
                end
            end
        end
    end

    assign up_ready = go[0];
    assign dn_valid = v_reg[RW-1];
    assign dn_root  = root_reg[RW-1];
    assign dn_par   = par_reg[RW-1];
    assign dn_nrm   = nrm_reg[RW-1];

endmodule

@@ src/srv_out.sv @@
// Parallel part -root*n, added to the perpendicular part and saturated.
`timescale 1ns / 1ps

module srv_out
    import srv_pkg::*;
#(
    parameter int FRAC_BITS = 12
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic up_valid,
    output logic up_ready,
    input  logic [root_w(FRAC_BITS)-1:0] up_root,
    input  vec_t up_par,
    input  vec_t up_nrm,
    output logic dn_valid,
    input  logic dn_ready,
    output vec_t dn_dir
);

    localparam int RW  = root_w(FRAC_BITS);
    localparam int MW  = RW + WORD_W + 1;
    localparam int NW  = MW + 2;
    localparam int RMW = NW - FRAC_BITS;
    localparam int XW  = RMW + 1;
    localparam int NS  = 3;

    localparam logic signed [NW-1:0] HALF   = NW'(1) <<< (FRAC_BITS - 1);
    localparam logic signed [XW-1:0] SAT_HI = XW'(WORD_MAX);
    localparam logic signed [XW-1:0] SAT_LO = XW'(WORD_MIN);

    logic [NS-1:0] v_reg, v_next, v_in;
    logic [NS:0]   go;

    logic signed [MW-1:0]  m_next  [3];
    logic signed [MW-1:0]  m_reg   [3];
    logic signed [RMW-1:0] rm_next [3];
    logic signed [RMW-1:0] rm_reg  [3];
    vec_t                  dir_next, dir_reg;
    vec_t                  par_reg [2];

    always_comb
    begin
        v_in   = {v_reg[NS-2:0], up_valid};
        go[NS] = dn_ready;
        for (int k = NS - 1; k >= 0; k--)
        begin
            go[k] = !v_reg[k] || go[k+1];
        end
        for (int k = 0; k < NS; k++)
        begin
            v_next[k] = go[k] ? v_in[k] : v_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            m_next[i] = $signed({1'b0, up_root}) * $signed(up_nrm[i]);
        end
    end

    // round of the negated product, half toward plus infinity
    always_comb
    begin : rm_calc
        logic signed [NW-1:0] nm;
        for (int i = 0; i < 3; i++)
        begin
            nm         = (HALF - NW'(m_reg[i])) >>> FRAC_BITS;
            rm_next[i] = nm[RMW-1:0];
        end
    end

    always_comb
    begin : sum_calc
        logic signed [XW-1:0] x;
        for (int i = 0; i < 3; i++)
        begin
            x = XW'(rm_reg[i]) + XW'($signed(par_reg[1][i]));
            if (x > SAT_HI)
            begin
                x = SAT_HI;
            end
            else if (x < SAT_LO)
            begin
                x = SAT_LO;
            end
            dir_next[i] = x[WORD_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (go[0] && v_in[0])
        begin
            m_reg      <= m_next;
            par_reg[0] <= up_par;
        end
        if (go[1] && v_in[1])
        begin
            rm_reg     <= rm_next;
            par_reg[1] <= par_reg[0];
        end
        if (go[2] && v_in[2])
        begin
            dir_reg    <= dir_next;
        end
    end

    assign up_ready = go[0];
    assign dn_valid = v_reg[NS-1];
    assign dn_dir   = dir_reg;

endmodule

@@ src/snell_refraction_vector.sv @@
// Top level: Snell refraction of a direction vector in signed fixed point.
//
//   channel  modport  word
//   ray      sink     in_dir_x/y/z, normal_x/y/z, index_ratio
//   result   source   out_dir_x/y/z
//
// One word per cycle sustained while result.ready stays high; the square root
// takes one result bit per stage.
// rst_n clears only the stage valid bits; data registers are not reset.
// Each stage loads when empty or when the stage ahead takes its word, so a
// stall on result fills bubbles first and ray.ready drops only when full.
`timescale 1ns / 1ps

module snell_refraction_vector
    import srv_pkg::*;
#(
    parameter int FRAC_BITS = 12
)
(
    input  logic clk,
    input  logic rst_n,
    srv_ray_if.sink   ray,
    srv_dir_if.source result
);

    localparam int CW = cos_w(FRAC_BITS);
    localparam int RW = root_w(FRAC_BITS);

    vec_t ray_dir, ray_nrm;

    logic                 d_valid, d_ready;
    vec_t                 d_dir, d_nrm;
    eta_t                 d_eta;
    logic signed [CW-1:0] d_cos;

    logic          p_valid, p_ready;
    vec_t          p_par, p_nrm;
    logic [2*RW-1:0] p_q;

    logic          s_valid, s_ready;
    logic [RW-1:0] s_root;
    vec_t          s_par, s_nrm;

    vec_t          o_dir;

    assign ray_dir = {ray.in_dir_z, ray.in_dir_y, ray.in_dir_x};
    assign ray_nrm = {ray.normal_z, ray.normal_y, ray.normal_x};

    srv_dot #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dot (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (ray.valid),
        .up_ready (ray.ready),
        .up_dir   (ray_dir),
        .up_nrm   (ray_nrm),
        .up_eta   (ray.index_ratio),
        .dn_valid (d_valid),
        .dn_ready (d_ready),
        .dn_dir   (d_dir),
        .dn_nrm   (d_nrm),
        .dn_eta   (d_eta),
        .dn_cos   (d_cos)
    );

    srv_perp #(
        .FRAC_BITS (FRAC_BITS)
    ) u_perp (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (d_valid),
        .up_ready (d_ready),
        .up_dir   (d_dir),
        .up_nrm   (d_nrm),
        .up_eta   (d_eta),
        .up_cos   (d_cos),
        .dn_valid (p_valid),
        .dn_ready (p_ready),
        .dn_par   (p_par),
        .dn_nrm   (p_nrm),
        .dn_q     (p_q)
    );

    srv_sqrt #(
        .FRAC_BITS (FRAC_BITS)
    ) u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (p_valid),
        .up_ready (p_ready),
        .up_q     (p_q),
        .up_par   (p_par),
        .up_nrm   (p_nrm),
        .dn_valid (s_valid),
        .dn_ready (s_ready),
        .dn_root  (s_root),
        .dn_par   (s_par),
        .dn_nrm   (s_nrm)
    );

    srv_out #(
        .FRAC_BITS (FRAC_BITS)
    ) u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (s_valid),
        .up_ready (s_ready),
        .up_root  (s_root),
        .up_par   (s_par),
        .up_nrm   (s_nrm),
        .dn_valid (result.valid),
        .dn_ready (result.ready),
        .dn_dir   (o_dir)
    );

    assign result.out_dir_x = o_dir[0];
    assign result.out_dir_y = o_dir[1];
    assign result.out_dir_z = o_dir[2];

endmodule
